// ===== design/rrsa_pkg.sv =====
// Shared types and codes for the round-robin space allocator.
// No dependencies; imported by the top level and the divider.
package rrsa_pkg;
	localparam logic [2:0] FUNC_DEFINE = 3'd0;
	localparam logic [2:0] FUNC_ADD    = 3'd1;
	localparam logic [2:0] FUNC_ALLOC  = 3'd2;
	localparam logic [2:0] FUNC_ADJUST = 3'd3;
	localparam logic [2:0] FUNC_QUERY  = 3'd4;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_NO_ROOM = 2'd1;
	localparam logic [1:0] STATUS_BAD     = 2'd2;

	localparam int DVD_W = 36;
	localparam int DVS_W = 17;

	typedef struct packed {
		logic [16:0] bsize;
		logic [39:0] free;
	} elem_t;
endpackage

// ===== design/round_robin_space_allocator_top.sv =====
// Round-robin first-fit space allocator: pool tables in registers, element table in memory.
// Depends on rrsa_pkg and rrsa_div.
//
// Usage: drive the request fields and raise start; the request is taken at an
// edge where start is high and busy is low. busy stays high while the request
// is worked on. Exactly one result follows per request: status, chosen_element,
// granted_mb and enough_space are valid in the single cycle that done is high.
// The receiver cannot hold the result off, so nothing stalls on the output.
// Define pool and bad requests finish in decode; add element writes the element
// memory and the pool sums; query compares registered products; adjust reads the
// element, divides unless its block size is zero, then applies; allocate visits
// elements in turn (read of the element memory, then the one-bit-per-cycle divider
// unless the element's block size is zero), up to the pool's element count.
// The next request may be taken in the cycle that done is high.
// Reset clears all pool state and the element valid bits at once; an element
// that is not valid reads as zero, so no clearing pass is needed. Define pool
// clears the valid bits of its pool in the decode state when its element count is in range.
module round_robin_space_allocator_top #(
	parameter int NUM_POOLS = 8,
	parameter int ELEMENTS_PER_POOL = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [2:0]  pool_index,
	input  logic [4:0]  element_index,
	input  logic [15:0] request_mb,
	input  logic [16:0] block_bytes,
	input  logic [39:0] total_blocks,
	input  logic [39:0] free_blocks_in,
	input  logic signed [31:0] byte_delta,
	input  logic [6:0]  min_free_override,
	input  logic [5:0]  element_count,
	input  logic [15:0] default_mb,
	input  logic [6:0]  min_free_percent,
	output logic        done,
	output logic [1:0]  status,
	output logic [4:0]  chosen_element,
	output logic [15:0] granted_mb,
	output logic        enough_space
);
	import rrsa_pkg::*;

	localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
	localparam int EW = (ELEMENTS_PER_POOL > 1) ? $clog2(ELEMENTS_PER_POOL) : 1;
	localparam int AW = PW + EW;
	localparam int DEPTH = NUM_POOLS << EW;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_ADD   = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_CHK   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_APPLY = 3'd6;
	localparam logic [2:0] S_QCMP  = 3'd7;

	logic [2:0] state_q;

	logic [2:0]  func_q;
	logic [2:0]  pool_q;
	logic [4:0]  elem_q;
	logic [15:0] req_q;
	logic [16:0] bsz_q;
	logic [39:0] tot_q;
	logic [39:0] fin_q;
	logic [31:0] delta_q;
	logic [6:0]  mover_q;
	logic [5:0]  ecnt_q;
	logic [15:0] defmb_q;
	logic [6:0]  minf_q;

	logic [5:0]  cnt_q  [NUM_POOLS];
	logic [EW-1:0] next_q [NUM_POOLS];
	logic [47:0] free_q [NUM_POOLS];
	logic [47:0] cap_q  [NUM_POOLS];
	logic [15:0] dmb_q  [NUM_POOLS];
	logic [6:0]  mfree_q[NUM_POOLS];

	elem_t       mem [DEPTH];
	elem_t       rdata_q;
	logic        rvld_q;
	logic [DEPTH-1:0] vld_q;
	logic        mem_we;
	elem_t       mem_wdata;

	logic [EW-1:0] idx_q;
	logic [5:0]    k_q;
	logic [15:0]   size_q;
	logic [47:0]   pcap_s1;
	logic [47:0]   pfree_s1;
	logic [54:0]   qa_s1;
	logic [54:0]   qb_s1;
	logic [31:0]   mag_q;

	logic          done_q;
	logic [1:0]    status_q;
	logic [4:0]    chosen_q;
	logic [15:0]   granted_q;
	logic          enough_q;

	logic [PW-1:0] p;
	logic [PW+2:0] p_wide;
	logic [EW-1:0] e;
	logic [EW+4:0] e_wide;
	logic [EW+4:0] idx_wide;
	logic [AW-1:0] addr;
	logic          pool_ok;
	logic          elem_ok;
	logic [5:0]    n;
	logic [16:0]   eb;
	logic [39:0]   ef;
	logic [8:0]    idx_inc;
	logic [EW-1:0] idx_wrap;
	logic [8:0]    start9;
	logic          last;
	logic          div_start;
	logic          div_done;
	logic [DVD_W-1:0] div_dvd;
	logic [DVD_W-1:0] quot;
	logic [40:0]   ef_add;
	logic [48:0]   pf_add;
	logic [48:0]   cap_sum;
	logic [48:0]   fr_sum;
	logic [47:0]   pq48;
	logic [47:0]   asub48;
	logic [39:0]   q40;

	assign p_wide = {PW'(0), pool_q};
	assign p = p_wide[PW-1:0];
	assign e_wide = {EW'(0), elem_q};
	assign e = e_wide[EW-1:0];
	assign idx_wide = {5'd0, idx_q};
	assign addr = {p, idx_q};
	assign pool_ok = ({4'd0, pool_q} < 7'(NUM_POOLS)) && (func_q <= FUNC_QUERY);
	assign n = cnt_q[p];
	assign elem_ok = ({1'b0, elem_q} < n) && (9'(elem_q) < 9'(ELEMENTS_PER_POOL));
	assign eb = rvld_q ? rdata_q.bsize : '0;
	assign ef = rvld_q ? rdata_q.free : '0;
	assign idx_inc = 9'(idx_q) + 9'd1;
	assign idx_wrap = (idx_inc >= 9'(n)) ? '0 : idx_inc[EW-1:0];
	assign start9 = 9'(next_q[p]);
	assign last = (k_q + 6'd1) == n;
	assign div_start = (state_q == S_CHK) && (eb != '0);
	assign div_dvd = (func_q == FUNC_ALLOC) ? {size_q, 20'd0} : {4'd0, mag_q};
	assign q40 = {4'd0, quot};
	assign ef_add = {1'b0, ef} + {1'b0, q40};
	assign pq48 = {25'd0, mag_q[31:9]};
	assign pf_add = {1'b0, free_q[p]} + {1'b0, pq48};
	assign asub48 = {21'd0, size_q, 11'd0};
	assign cap_sum = {1'b0, cap_q[p]} + {1'b0, pcap_s1};
	assign fr_sum = {1'b0, free_q[p]} + {1'b0, pfree_s1};

	rrsa_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dvd),
		.divisor(eb),
		.done(div_done),
		.quotient(quot)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_wdata = rdata_q;
		if (state_q == S_ADD) begin
			mem_we = 1'b1;
			mem_wdata.bsize = bsz_q;
			mem_wdata.free = fin_q;
		end else if (state_q == S_APPLY) begin
			mem_wdata.bsize = eb;
			if (func_q == FUNC_ALLOC) begin
				mem_we = ef >= q40;
				mem_wdata.free = ef - q40;
			end else begin
				mem_we = 1'b1;
				if (delta_q[31]) begin
					mem_wdata.free = (q40 >= ef) ? '0 : ef - q40;
				end else begin
					mem_wdata.free = ef_add[40] ? '1 : ef_add[39:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[addr] <= mem_wdata;
		rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q <= 1'b0;
			status_q <= STATUS_OK;
			chosen_q <= '0;
			granted_q <= '0;
			enough_q <= 1'b0;
			idx_q <= '0;
			k_q <= '0;
			size_q <= '0;
			vld_q <= '0;
			rvld_q <= 1'b0;
			for (int i = 0; i < NUM_POOLS; i++) begin
				cnt_q[i] <= '0;
				next_q[i] <= '0;
				free_q[i] <= '0;
				cap_q[i] <= '0;
				dmb_q[i] <= '0;
				mfree_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			rvld_q <= vld_q[addr];
			if (mem_we) vld_q[addr] <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_DEC;
				end
				S_DEC: begin
					status_q <= STATUS_OK;
					chosen_q <= '0;
					enough_q <= 1'b0;
					granted_q <= '0;
					if (!pool_ok) begin
						status_q <= STATUS_BAD;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						case (func_q)
							FUNC_DEFINE: begin
								if (9'(ecnt_q) > 9'(ELEMENTS_PER_POOL)) begin
									status_q <= STATUS_BAD;
								end else begin
									cnt_q[p] <= ecnt_q;
									dmb_q[p] <= defmb_q;
									mfree_q[p] <= minf_q;
									next_q[p] <= '0;
									free_q[p] <= '0;
									cap_q[p] <= '0;
									for (int i = 0; i < DEPTH; i++) begin
										if (PW'(i >> EW) == p) vld_q[i] <= 1'b0;
									end
								end
								done_q <= 1'b1;
								state_q <= S_IDLE;
							end
							FUNC_ADD, FUNC_ADJUST: begin
								if (!elem_ok) begin
									status_q <= STATUS_BAD;
									done_q <= 1'b1;
									state_q <= S_IDLE;
								end else begin
									idx_q <= e;
									state_q <= (func_q == FUNC_ADD) ? S_ADD : S_RD;
								end
							end
							FUNC_ALLOC: begin
								granted_q <= (req_q != 16'd0) ? req_q : dmb_q[p];
								size_q <= (req_q != 16'd0) ? req_q : dmb_q[p];
								k_q <= '0;
								idx_q <= (start9 < 9'(n)) ? next_q[p] : '0;
								if (n == 6'd0) begin
									status_q <= STATUS_NO_ROOM;
									done_q <= 1'b1;
									state_q <= S_IDLE;
								end else begin
									state_q <= S_RD;
								end
							end
							default: begin
								state_q <= S_QCMP;
							end
						endcase
					end
				end
				S_ADD: begin
					cap_q[p] <= cap_sum[48] ? '1 : cap_sum[47:0];
					free_q[p] <= fr_sum[48] ? '1 : fr_sum[47:0];
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_RD: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (eb != '0) begin
						state_q <= S_DIV;
					end else if (func_q == FUNC_ADJUST) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else if (last) begin
						status_q <= STATUS_NO_ROOM;
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q + 6'd1;
						idx_q <= idx_wrap;
						state_q <= S_RD;
					end
				end
				S_DIV: begin
					if (div_done) state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (func_q == FUNC_ALLOC) begin
						if (ef >= q40) begin
							chosen_q <= idx_wide[4:0];
							next_q[p] <= idx_wrap;
							free_q[p] <= (asub48 >= free_q[p]) ? '0 : free_q[p] - asub48;
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else if (last) begin
							status_q <= STATUS_NO_ROOM;
							done_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							k_q <= k_q + 6'd1;
							idx_q <= idx_wrap;
							state_q <= S_RD;
						end
					end else begin
						if (delta_q[31]) begin
							free_q[p] <= (pq48 >= free_q[p]) ? '0 : free_q[p] - pq48;
						end else begin
							free_q[p] <= pf_add[48] ? '1 : pf_add[47:0];
						end
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_QCMP: begin
					enough_q <= (cap_q[p] != '0) && (qa_s1 > qb_s1);
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			func_q <= func;
			pool_q <= pool_index;
			elem_q <= element_index;
			req_q <= request_mb;
			bsz_q <= block_bytes;
			tot_q <= total_blocks;
			fin_q <= free_blocks_in;
			delta_q <= byte_delta;
			mover_q <= min_free_override;
			ecnt_q <= element_count;
			defmb_q <= default_mb;
			minf_q <= min_free_percent;
		end
		if (state_q == S_DEC) begin
			pcap_s1 <= tot_q * bsz_q[16:9];
			pfree_s1 <= fin_q * bsz_q[16:9];
			qa_s1 <= free_q[p] * 7'd100;
			qb_s1 <= ((mover_q != 7'd0) ? mover_q : mfree_q[p]) * cap_q[p];
			mag_q <= delta_q[31] ? (~delta_q + 32'd1) : delta_q;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = done_q;
	assign status = status_q;
	assign chosen_element = chosen_q;
	assign granted_mb = granted_q;
	assign enough_space = enough_q;
endmodule

// ===== design/rrsa_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on rrsa_pkg for operand widths.
module rrsa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rrsa_pkg::DVD_W-1:0] dividend,
	input  logic [rrsa_pkg::DVS_W-1:0] divisor,
	output logic                      done,
	output logic [rrsa_pkg::DVD_W-1:0] quotient
);
	import rrsa_pkg::*;

	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [5:0]       cnt_q;
	logic             done_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W+1:0] diff;

	assign shifted = {rem_q, quo_q[DVD_W-1]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 6'(DVD_W);
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != 6'd0) begin
			if (!diff[DVS_W+1]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
endmodule

// ===== design/rrsa_chk.sv =====
// Port-level checks for the space allocator top level.
// Depends on round_robin_space_allocator_top; bound to it below.
module rrsa_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [15:0] granted_mb,
	input logic        enough_space
);
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done) else $error("request not taken");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3) else $error("undefined status");
	a_bad: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != 2'd0 |-> !enough_space && (status != 2'd2 || granted_mb == 16'd0))
		else $error("failed request carries data");
endmodule

bind round_robin_space_allocator_top rrsa_chk u_rrsa_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.granted_mb(granted_mb),
	.enough_space(enough_space)
);

// ===== bench/round_robin_space_allocator_top_tb.sv =====
// Self-checking bench for round_robin_space_allocator_top: directed and random requests
// over all five operations, results checked against an in-bench predictor of the pool tables.
// Depends on rrsa_pkg and the allocator RTL.
`timescale 1ns / 1ps
module round_robin_space_allocator_top_tb;
	import rrsa_pkg::*;

	localparam int NPOOL = 8;
	localparam int NELEM = 32;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam logic [63:0] MAX40 = 64'hFF_FFFF_FFFF;
	localparam logic [63:0] MAX48 = 64'hFFFF_FFFF_FFFF;

	typedef struct {
		logic [2:0]  fn;
		logic [2:0]  pool;
		logic [4:0]  elem;
		logic [15:0] req_mb;
		logic [16:0] bsz;
		logic [39:0] tot;
		logic [39:0] fin;
		logic [31:0] delta;
		logic [6:0]  mover;
		logic [5:0]  ecnt;
		logic [15:0] defmb;
		logic [6:0]  minf;
		bit          hold;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [4:0]  chosen;
		logic [15:0] granted;
		logic        enough;
	} result_t;

	logic clk, arst_n, start, busy, done;
	logic [1:0] status;
	logic [4:0] chosen_element;
	logic [15:0] granted_mb;
	logic enough_space;
	request_t cur;

	request_t pending_requests[$];
	result_t  expected_results[$];
	int errors, accepted, checked, granted_cnt, idle_cycles;

	logic [16:0] tbl_bsize[NPOOL][NELEM];
	logic [63:0] tbl_free[NPOOL][NELEM];
	logic [5:0]  tbl_count[NPOOL];
	logic [4:0]  tbl_next[NPOOL];
	logic [63:0] tbl_pool_free[NPOOL];
	logic [63:0] tbl_pool_cap[NPOOL];
	logic [15:0] tbl_defmb[NPOOL];
	logic [6:0]  tbl_minf[NPOOL];
	int gen_count[NPOOL];

	round_robin_space_allocator_top u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(cur.fn), .pool_index(cur.pool), .element_index(cur.elem),
		.request_mb(cur.req_mb), .block_bytes(cur.bsz), .total_blocks(cur.tot),
		.free_blocks_in(cur.fin), .byte_delta(cur.delta),
		.min_free_override(cur.mover), .element_count(cur.ecnt),
		.default_mb(cur.defmb), .min_free_percent(cur.minf),
		.done(done), .status(status), .chosen_element(chosen_element),
		.granted_mb(granted_mb), .enough_space(enough_space)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] mx);
		if (a >= mx || b > mx - a)
			return mx;
		return a + b;
	endfunction

	function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
		return (b >= a) ? 64'd0 : a - b;
	endfunction

	function automatic result_t allocate_space(request_t r);
		result_t res;
		int p, n, i, k;
		logic [63:0] size, reqbytes, mag, eq, pq;
		logic [31:0] negd;
		logic [63:0] thr;
		bit found;
		res = '{default: '0};
		p = int'(r.pool);
		if (r.fn > FUNC_QUERY) begin
			res.status = STATUS_BAD;
		end else if (r.fn == FUNC_DEFINE) begin
			if (r.ecnt > NELEM) begin
				res.status = STATUS_BAD;
			end else begin
				tbl_count[p] = r.ecnt;
				tbl_defmb[p] = r.defmb;
				tbl_minf[p] = r.minf;
				tbl_next[p] = '0;
				tbl_pool_free[p] = '0;
				tbl_pool_cap[p] = '0;
				for (i = 0; i < NELEM; i++) begin
					tbl_bsize[p][i] = '0;
					tbl_free[p][i] = '0;
				end
			end
		end else if (r.fn == FUNC_ADD) begin
			if (r.elem >= tbl_count[p]) begin
				res.status = STATUS_BAD;
			end else begin
				tbl_bsize[p][r.elem] = r.bsz;
				tbl_free[p][r.elem] = 64'(r.fin);
				tbl_pool_cap[p] = sat_add(tbl_pool_cap[p], 64'(r.tot) * 64'(r.bsz / 512), MAX48);
				tbl_pool_free[p] = sat_add(tbl_pool_free[p], 64'(r.fin) * 64'(r.bsz / 512), MAX48);
			end
		end else if (r.fn == FUNC_ALLOC) begin
			n = int'(tbl_count[p]);
			size = (r.req_mb != 0) ? 64'(r.req_mb) : 64'(tbl_defmb[p]);
			reqbytes = size << 20;
			res.granted = size[15:0];
			if (n == 0) begin
				res.status = STATUS_NO_ROOM;
			end else begin
				i = (int'(tbl_next[p]) < n) ? int'(tbl_next[p]) : 0;
				found = 0;
				for (k = 0; k < n && !found; k++) begin
					if (tbl_bsize[p][i] != 0 && tbl_free[p][i] >= reqbytes / tbl_bsize[p][i])
						found = 1;
					else
						i = (i + 1 >= n) ? 0 : i + 1;
				end
				if (!found) begin
					res.status = STATUS_NO_ROOM;
				end else begin
					res.chosen = 5'(i);
					tbl_next[p] = 5'((i + 1 >= n) ? 0 : i + 1);
					tbl_pool_free[p] = sat_sub(tbl_pool_free[p], reqbytes / 512);
					tbl_free[p][i] = tbl_free[p][i] - reqbytes / tbl_bsize[p][i];
				end
			end
		end else if (r.fn == FUNC_ADJUST) begin
			if (r.elem >= tbl_count[p]) begin
				res.status = STATUS_BAD;
			end else if (tbl_bsize[p][r.elem] != 0) begin
				negd = ~r.delta + 32'd1;
				mag = r.delta[31] ? 64'(negd) : 64'(r.delta);
				eq = mag / tbl_bsize[p][r.elem];
				pq = mag / 512;
				if (r.delta[31]) begin
					tbl_free[p][r.elem] = sat_sub(tbl_free[p][r.elem], eq);
					tbl_pool_free[p] = sat_sub(tbl_pool_free[p], pq);
				end else begin
					tbl_free[p][r.elem] = sat_add(tbl_free[p][r.elem], eq, MAX40);
					tbl_pool_free[p] = sat_add(tbl_pool_free[p], pq, MAX48);
				end
			end
		end else begin
			thr = (r.mover != 0) ? 64'(r.mover) : 64'(tbl_minf[p]);
			res.enough = (tbl_pool_cap[p] != 0) &&
				(tbl_pool_free[p] * 100 > thr * tbl_pool_cap[p]);
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch on result %0d: %s got %0d expected %0d", checked, what, got, want);
		errors++;
	endtask

	// drive requests; hold a pause marker until every result is back
	always @(posedge clk or negedge arst_n) begin
		result_t res;
		if (!arst_n) begin
			start <= 1'b0;
			cur <= '{default: '0};
		end else begin
			if (start && !busy) begin
				res = allocate_space(cur);
				expected_results.push_back(res);
				if (cur.fn == FUNC_ALLOC && res.status == STATUS_OK) granted_cnt++;
				accepted++;
			end
			if (!start || !busy) begin
				if (pending_requests.size() != 0 && pending_requests[0].hold) begin
					if (expected_results.size() == 0)
						void'(pending_requests.pop_front());
					start <= 1'b0;
				end else if (pending_requests.size() != 0 &&
					((accepted > 300 && accepted < 500) || $urandom_range(0, 99) >= 6)) begin
					cur <= pending_requests.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// check results and watch for a hang
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$display("result with no request outstanding");
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (status != want.status) report_mismatch("status", status, want.status);
					if (chosen_element != want.chosen)
						report_mismatch("chosen_element", chosen_element, want.chosen);
					if (granted_mb != want.granted)
						report_mismatch("granted_mb", granted_mb, want.granted);
					if (enough_space != want.enough)
						report_mismatch("enough_space", enough_space, want.enough);
					checked++;
				end
			end
			if (done || (start && !busy))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired with %0d results outstanding", expected_results.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic request_t noise_request();
		request_t r;
		r.fn = 3'($urandom_range(0, 7));
		r.pool = 3'($urandom_range(0, 7));
		r.elem = 5'($urandom_range(0, 31));
		r.req_mb = 16'($urandom);
		r.bsz = 17'($urandom_range(0, 131071));
		r.tot = 40'({$urandom, $urandom});
		r.fin = 40'({$urandom, $urandom});
		r.delta = $urandom;
		r.mover = 7'($urandom_range(0, 127));
		r.ecnt = 6'($urandom_range(0, 63));
		r.defmb = 16'($urandom);
		r.minf = 7'($urandom_range(0, 127));
		r.hold = 0;
		return r;
	endfunction

	task automatic queue_request(request_t r);
		if (r.fn == FUNC_DEFINE && r.ecnt <= NELEM)
			gen_count[r.pool] = int'(r.ecnt);
		pending_requests.push_back(r);
	endtask

	task automatic directed(logic [2:0] fn, int pool, int elem, int req, int bsz,
		logic [39:0] tot, logic [39:0] fin, logic [31:0] delta, int mover, int ecnt,
		int defmb, int minf);
		request_t r;
		r = noise_request();
		r.fn = fn; r.pool = 3'(pool); r.elem = 5'(elem); r.req_mb = 16'(req);
		r.bsz = 17'(bsz);
		r.tot = tot; r.fin = fin; r.delta = delta; r.mover = 7'(mover); r.ecnt = 6'(ecnt);
		r.defmb = 16'(defmb); r.minf = 7'(minf);
		queue_request(r);
	endtask

	function automatic request_t random_request();
		request_t r;
		int pick;
		r = noise_request();
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			r.fn = FUNC_DEFINE;
			pick = $urandom_range(0, 99);
			r.ecnt = 6'((pick < 5) ? 32 :
				(pick < 8) ? $urandom_range(33, 63) : $urandom_range(1, 8));
			r.defmb = 16'($urandom_range(0, 64));
			r.minf = 7'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) :
				$urandom_range(0, 100));
		end else if (pick < 33) begin
			r.fn = FUNC_ADD;
			if ($urandom_range(0, 9) != 0) r.elem = 5'($urandom_range(0, gen_count[r.pool]));
			pick = $urandom_range(0, 19);
			r.bsz = (pick == 0) ? 17'd0 : (pick == 1) ? r.bsz : 17'(512 * $urandom_range(1, 128));
			if ($urandom_range(0, 9) != 0) begin
				r.tot = 40'($urandom_range(0, 1 << 22));
				r.fin = 40'($urandom_range(0, 32'(r.tot)));
			end
		end else if (pick < 65) begin
			r.fn = FUNC_ALLOC;
			pick = $urandom_range(0, 19);
			r.req_mb = (pick < 4) ? 16'd0 : (pick == 4) ? r.req_mb : 16'($urandom_range(1, 16));
		end else if (pick < 85) begin
			r.fn = FUNC_ADJUST;
			if ($urandom_range(0, 9) != 0) r.elem = 5'($urandom_range(0, gen_count[r.pool]));
			if ($urandom_range(0, 1)) r.delta = $signed(r.delta) >>> $urandom_range(0, 31);
		end else if (pick < 97) begin
			r.fn = FUNC_QUERY;
			if ($urandom_range(0, 1)) r.mover = '0;
			else r.mover = 7'($urandom_range(0, 100));
		end else begin
			r.fn = 3'($urandom_range(5, 7));
		end
		return r;
	endfunction

	initial begin
		request_t r;
		arst_n = 1'b0;
		errors = 0; accepted = 0; checked = 0; granted_cnt = 0; idle_cycles = 0;
		foreach (gen_count[i]) gen_count[i] = 0;
		foreach (tbl_count[p]) begin
			tbl_count[p] = 0; tbl_next[p] = 0; tbl_pool_free[p] = 0; tbl_pool_cap[p] = 0;
			tbl_defmb[p] = 0; tbl_minf[p] = 0;
			for (int e = 0; e < NELEM; e++) begin
				tbl_bsize[p][e] = 0;
				tbl_free[p][e] = 0;
			end
		end

		directed(FUNC_DEFINE, 0, 0, 0, 0, 0, 0, 0, 0, 4, 10, 20);
		directed(FUNC_DEFINE, 1, 0, 0, 0, 0, 0, 0, 0, 33, 5, 5);
		directed(FUNC_DEFINE, 7, 0, 0, 0, 0, 0, 0, 0, 32, 65535, 100);
		directed(FUNC_ADD, 0, 0, 0, 65536, MAX40[39:0], MAX40[39:0], 0, 0, 0, 0, 0);
		directed(FUNC_ADD, 0, 1, 0, 0, 1000, 1000, 0, 0, 0, 0, 0);
		directed(FUNC_ADD, 0, 2, 0, 131071, 4096, 2048, 0, 0, 0, 0, 0);
		directed(FUNC_ADD, 0, 4, 0, 512, 10, 10, 0, 0, 0, 0, 0);
		directed(FUNC_ALLOC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		directed(FUNC_ALLOC, 0, 0, 65535, 0, 0, 0, 0, 0, 0, 0, 0);
		directed(FUNC_ALLOC, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		directed(FUNC_ALLOC, 2, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
		directed(FUNC_ADJUST, 0, 1, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
		directed(FUNC_ADJUST, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0);
		directed(FUNC_ADJUST, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0);
		directed(FUNC_ADJUST, 0, 9, 0, 0, 0, 0, 32'hFFFF_FE00, 0, 0, 0, 0);
		directed(FUNC_QUERY, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		directed(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		directed(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 100, 0, 0, 0);
		directed(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
		directed(3'd5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		directed(3'd6, 7, 31, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		directed(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		r = '{default: '0};
		r.hold = 1;
		pending_requests.push_back(r);
		for (int n = 0; n < 1130; n++) begin
			if (n == 600) pending_requests.push_back(r);
			queue_request(random_request());
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_requests.size() != 0 || start) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("ran %0d requests across define, add, allocate, adjust, query and bad codes",
			accepted);
		$display("checked %0d results, %0d allocations granted", checked, granted_cnt);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/rrsa_pkg.sv
design/rrsa_div.sv
design/round_robin_space_allocator_top.sv
design/rrsa_chk.sv
bench/round_robin_space_allocator_top_tb.sv
